@@ rtl/tfci_pkg.sv @@
// Shared types, codes and helpers for the TLSF free-class index.
// No dependencies; every other file of the block but tfci_ram refers to this package by scoped names.
package tfci_pkg;

	// Size and class geometry
	localparam int SIZE_W     = 22;
	localparam int REQ_W      = SIZE_W + 1;
	localparam int FL_W       = 4;
	localparam int SL_W       = 3;
	localparam int SL_COUNT   = 8;
	localparam int FL_MAX     = 16;
	localparam int LEVELS_DEF = 16;
	localparam int MIN_BLOCK  = 64;
	localparam int MIN_REQ    = 64 + 8;
	localparam int FL_BIAS    = 6;

	// Per-class free-block count
	localparam int                COUNT_W   = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// Command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// Status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_NOFIT = 3'd1;
	localparam logic [2:0] ST_SMALL = 3'd2;
	localparam logic [2:0] ST_RANGE = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;
	localparam logic [2:0] ST_FULL  = 3'd5;

	// Class of a free block, as decoded from its size
	typedef struct packed {
		logic            too_small;
		logic            oor;
		logic [FL_W-1:0] fl;
		logic [SL_W-1:0] sl;
	} class_t;

	// Outcome of an allocation lookup
	typedef struct packed {
		logic            found;
		logic [FL_W-1:0] fl;
		logic [SL_W-1:0] sl;
	} find_t;

	// Position of the highest set bit (0 for a zero word)
	function automatic logic [4:0] msb_pos(input logic [REQ_W-1:0] v);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < REQ_W; i++) begin
			if (v[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

endpackage

@@ rtl/tfci_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; read during a write to the same address returns the old word.
module tfci_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 128,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; hold the word while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/tfci_class.sv @@
// Size-to-class decoder for insert and remove commands.
// Depends on tfci_pkg for the class type, geometry and the MSB helper.
module tfci_class #(
	parameter int LEVELS = tfci_pkg::LEVELS_DEF
) (
	input  logic [tfci_pkg::SIZE_W-1:0] size,
	output tfci_pkg::class_t            cls
);

	logic [4:0]                     msb;
	logic [4:0]                     fl5;
	logic [tfci_pkg::SIZE_W-1:0]    shifted;

	// First level from the MSB position, second level from the next three bits
	always_comb begin
		msb           = tfci_pkg::msb_pos({1'b0, size});
		fl5           = msb - 5'(tfci_pkg::FL_BIAS);
		shifted       = size >> (fl5 + 5'd3);
		cls.too_small = (size < tfci_pkg::SIZE_W'(tfci_pkg::MIN_BLOCK));
		cls.fl        = fl5[tfci_pkg::FL_W-1:0];
		cls.sl        = shifted[tfci_pkg::SL_W-1:0];
		cls.oor       = (fl5 >= 5'(LEVELS));
	end

endmodule

@@ rtl/tfci_find.sv @@
// Allocation lookup: request rounding, start class and find-first-set over the bitmap.
// Depends on tfci_pkg for the lookup result type, geometry and the MSB helper.
module tfci_find #(
	parameter int LEVELS = tfci_pkg::LEVELS_DEF,
	parameter int NUM_FL = (LEVELS < tfci_pkg::FL_MAX) ? LEVELS : tfci_pkg::FL_MAX,
	parameter int DEPTH  = NUM_FL * tfci_pkg::SL_COUNT,
	parameter int IDX_W  = $clog2(DEPTH)
) (
	input  logic [tfci_pkg::SIZE_W-1:0] size,
	input  logic [DEPTH-1:0]            bitmap,
	output tfci_pkg::find_t             res
);

	logic [tfci_pkg::REQ_W-1:0] req;
	logic [tfci_pkg::REQ_W-1:0] shifted;
	logic [4:0]                 msb;
	logic [4:0]                 fl5;
	logic [3:0]                 sl4;
	logic [4:0]                 start_fl;
	logic [2:0]                 start_sl;
	logic [7:0]                 start;
	logic                       oor;
	logic [DEPTH-1:0]           masked;
	logic [DEPTH-1:0]           lowest;
	logic [IDX_W-1:0]           pos;
	logic [6:0]                 pos7;

	// Round the request up, clamp to the minimum and take the next class up
	always_comb begin
		req = {{1'b0, size[tfci_pkg::SIZE_W-1:3]} + 20'd1, 3'b000};
		if (req < tfci_pkg::REQ_W'(tfci_pkg::MIN_REQ)) begin
			req = tfci_pkg::REQ_W'(tfci_pkg::MIN_REQ);
		end
		msb     = tfci_pkg::msb_pos(req);
		fl5     = msb - 5'(tfci_pkg::FL_BIAS);
		shifted = req >> (fl5 + 5'd3);
		sl4     = {1'b0, shifted[2:0]} + 4'd1;
		if (sl4 == 4'(tfci_pkg::SL_COUNT)) begin
			start_fl = fl5 + 5'd1;
			start_sl = 3'd0;
		end else begin
			start_fl = fl5;
			start_sl = sl4[2:0];
		end
		start = {start_fl, start_sl};
		oor   = (start_fl >= 5'(NUM_FL));
	end

	// Mask classes below the start and isolate the lowest non-empty one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			masked[i] = bitmap[i] && (8'(i) >= start);
		end
		lowest = masked & (~masked + DEPTH'(1));
		pos    = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lowest[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
		pos7      = 7'(pos);
		res.found = (|masked) && !oor;
		res.fl    = pos7[6:3];
		res.sl    = pos7[2:0];
	end

endmodule

@@ rtl/tlsf_free_class_index.sv @@
// TLSF free-class index: per-class free-block counts with a class bitmap and lookup.
// Each word passes the input register and then the result register, where its result word
// shows up and is held until out_ready takes it.
// Throughput: one word per cycle while no result is held; the count RAM read at accept plus one
// write-back forwarding register let a word update a count that its predecessor just wrote.
// Reset clears pipeline valids, the class bitmap and the per-class count valid bits;
// no clearing pass, the block takes words right after reset.
module tlsf_free_class_index #(
	parameter int LEVELS = tfci_pkg::LEVELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [tfci_pkg::SIZE_W-1:0] size,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [tfci_pkg::FL_W-1:0]   first_level,
	output logic [tfci_pkg::SL_W-1:0]   second_level
);

	localparam int NUM_FL  = (LEVELS < tfci_pkg::FL_MAX) ? LEVELS : tfci_pkg::FL_MAX;
	localparam int DEPTH   = NUM_FL * tfci_pkg::SL_COUNT;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int COUNT_W = tfci_pkg::COUNT_W;

	tfci_pkg::class_t            cls_in;
	logic [6:0]                  cls7_in;
	logic [IDX_W-1:0]            idx_in;
	logic                        accept;

	logic                        valid_s1;
	logic [1:0]                  cmd_s1;
	logic [tfci_pkg::SIZE_W-1:0] size_s1;
	tfci_pkg::class_t            cls_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic                        cvalid_s1;

	logic [COUNT_W-1:0]          rdata;
	logic [COUNT_W-1:0]          cur;
	logic [COUNT_W-1:0]          nxt;
	logic                        fwd;
	logic                        is_ins;
	logic                        is_rem;
	logic                        full;
	logic                        empty;
	logic                        commit;
	logic                        advance;
	tfci_pkg::find_t             found;

	logic [2:0]                  st_d;
	logic [tfci_pkg::FL_W-1:0]   fl_d;
	logic [tfci_pkg::SL_W-1:0]   sl_d;

	logic                        valid_s2;
	logic [2:0]                  status_s2;
	logic [tfci_pkg::FL_W-1:0]   fl_s2;
	logic [tfci_pkg::SL_W-1:0]   sl_s2;

	logic [DEPTH-1:0]            bitmap_q;
	logic [DEPTH-1:0]            cvalid_q;
	logic                        lastw_valid_q;
	logic [IDX_W-1:0]            lastw_addr_q;
	logic [COUNT_W-1:0]          lastw_data_q;

	// Handshake: the result register frees the input stage
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// Decode the class at the input so the count RAM read starts at accept
	tfci_class #(.LEVELS(LEVELS)) u_class (
		.size (size),
		.cls  (cls_in)
	);

	assign cls7_in = {cls_in.fl, cls_in.sl};
	assign idx_in  = cls7_in[IDX_W-1:0];

	tfci_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_count_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (idx_s1),
		.wdata (nxt),
		.re    (accept),
		.raddr (idx_in),
		.rdata (rdata)
	);

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= command;
			size_s1   <= size;
			cls_s1    <= cls_in;
			idx_s1    <= idx_in;
			cvalid_s1 <= cvalid_q[idx_in];
		end
	end

	// Current count: forward the last write-back, else RAM word or reset zero
	always_comb begin
		fwd    = lastw_valid_q && (lastw_addr_q == idx_s1);
		cur    = fwd ? lastw_data_q : (cvalid_s1 ? rdata : '0);
		is_ins = (cmd_s1 == tfci_pkg::CMD_INSERT);
		is_rem = (cmd_s1 == tfci_pkg::CMD_REMOVE);
		full   = (cur == tfci_pkg::COUNT_MAX);
		empty  = (cur == '0);
		nxt    = is_ins ? (cur + COUNT_W'(1)) : (cur - COUNT_W'(1));
		commit = valid_s1 && advance && !cls_s1.too_small && !cls_s1.oor
			&& ((is_ins && !full) || (is_rem && !empty));
	end

	tfci_find #(.LEVELS(LEVELS)) u_find (
		.size   (size_s1),
		.bitmap (bitmap_q),
		.res    (found)
	);

	// Select the result word for the command
	always_comb begin
		st_d = tfci_pkg::ST_OK;
		fl_d = '0;
		sl_d = '0;
		case (cmd_s1) inside
			tfci_pkg::CMD_INSERT, tfci_pkg::CMD_REMOVE: begin
				if (cls_s1.too_small) begin
					st_d = tfci_pkg::ST_SMALL;
				end else begin
					fl_d = cls_s1.fl;
					sl_d = cls_s1.sl;
					if (cls_s1.oor) begin
						st_d = tfci_pkg::ST_RANGE;
					end else if (is_ins && full) begin
						st_d = tfci_pkg::ST_FULL;
					end else if (is_rem && empty) begin
						st_d = tfci_pkg::ST_EMPTY;
					end
				end
			end
			tfci_pkg::CMD_LOOKUP: begin
				if (found.found) begin
					fl_d = found.fl;
					sl_d = found.sl;
				end else begin
					st_d = tfci_pkg::ST_NOFIT;
				end
			end
			default: begin
				st_d = tfci_pkg::ST_OK;
			end
		endcase
	end

	// Commit the count update to the bitmap, valid bits and forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q      <= '0;
			cvalid_q      <= '0;
			lastw_valid_q <= 1'b0;
		end else if (commit) begin
			bitmap_q[idx_s1] <= is_ins || (nxt != '0);
			cvalid_q[idx_s1] <= 1'b1;
			lastw_valid_q    <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			lastw_addr_q <= idx_s1;
			lastw_data_q <= nxt;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload; hold while stalled
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_s2 <= st_d;
			fl_s2     <= fl_d;
			sl_s2     <= sl_d;
		end
	end

	assign out_valid    = valid_s2;
	assign status       = status_s2;
	assign first_level  = fl_s2;
	assign second_level = sl_s2;

	// A class bit is only ever set where its count has been written
	a_bitmap_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(bitmap_q & ~cvalid_q) == '0)
		else $error("class bit set without a written count");

	// The forwarding register always shadows a written count entry
	a_fwd_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		lastw_valid_q |-> cvalid_q[lastw_addr_q])
		else $error("forwarded entry not marked written");

	// An accepted insert leaves its class bit set
	a_insert_sets_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && is_ins) |=> bitmap_q[$past(idx_s1)])
		else $error("insert did not set class bit");

	// The input side only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without a held result");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the TLSF free-class index (tlsf_free_class_index).
// Depends on rtl/tfci_pkg.sv and rtl/tlsf_free_class_index.sv; drives and checks both
// valid/ready channels against an in-bench model of the class counts and bitmap.
`timescale 1ns / 1ps

module testbench;

	localparam int         NUM_LEVELS = tfci_pkg::LEVELS_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         HOLD_CYCLES = 300;
	localparam int         CHUNK_WORDS = 125;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [21:0] sz;
	} request_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] fl;
		logic [2:0] sl;
	} class_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = '0;
	logic [21:0] size = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [3:0]  first_level;
	logic [2:0]  second_level;

	// Model state: one bitmap byte per first level, one count per class
	logic [7:0]  class_bits [NUM_LEVELS] = '{default: '0};
	logic [15:0] class_free [NUM_LEVELS * 8] = '{default: '0};

	request_t      request_words [$];
	class_report_t due_reports [$];

	int  idle_mode = 1;
	bit  want_hold = 1'b0;
	bit  hold_taken = 1'b0;
	bit  in_acc = 1'b0;
	bit  out_acc = 1'b0;
	int  gap_left = 0;
	int  ready_wait = 0;
	int  errors = 0;
	int  cmd_seen [4] = '{default: 0};
	int  status_seen [8] = '{default: 0};

	tlsf_free_class_index #(
		.LEVELS(NUM_LEVELS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.size        (size),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.first_level (first_level),
		.second_level(second_level)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Position of the highest set bit
	function automatic int top_bit(input logic [22:0] v);
		int p;
		p = 0;
		for (int i = 0; i < 23; i++) begin
			if (v[i]) begin
				p = i;
			end
		end
		return p;
	endfunction

	// Apply one word to the class index and return the report it should produce
	function automatic class_report_t index_step(input logic [1:0] cmd, input logic [21:0] sz);
		class_report_t r;
		int            fl;
		int            sl;
		int            idx;
		logic [22:0]   req;
		logic [7:0]    mask;
		bit            found;
		r = '{tfci_pkg::ST_OK, 4'd0, 3'd0};
		if (cmd == tfci_pkg::CMD_INSERT || cmd == tfci_pkg::CMD_REMOVE) begin
			if (sz < tfci_pkg::MIN_BLOCK) begin
				r.status = tfci_pkg::ST_SMALL;
				return r;
			end
			fl = top_bit({1'b0, sz}) - tfci_pkg::FL_BIAS;
			sl = (sz >> (fl + 3)) & 7;
			r.fl = 4'(fl);
			r.sl = 3'(sl);
			if (fl >= NUM_LEVELS) begin
				r.status = tfci_pkg::ST_RANGE;
				return r;
			end
			idx = fl * 8 + sl;
			if (cmd == tfci_pkg::CMD_INSERT) begin
				if (class_free[idx] == tfci_pkg::COUNT_MAX) begin
					r.status = tfci_pkg::ST_FULL;
				end else begin
					class_free[idx]++;
					class_bits[fl][sl] = 1'b1;
				end
			end else begin
				if (class_free[idx] == 16'd0) begin
					r.status = tfci_pkg::ST_EMPTY;
				end else begin
					class_free[idx]--;
					if (class_free[idx] == 16'd0) begin
						class_bits[fl][sl] = 1'b0;
					end
				end
			end
		end else if (cmd == tfci_pkg::CMD_LOOKUP) begin
			req = ((23'(sz) >> 3) + 23'd1) << 3;
			if (req < tfci_pkg::MIN_REQ) begin
				req = tfci_pkg::MIN_REQ;
			end
			fl = top_bit(req) - tfci_pkg::FL_BIAS;
			sl = ((req >> (fl + 3)) & 7) + 1;
			if (sl == 8) begin
				fl++;
				sl = 0;
			end
			r.status = tfci_pkg::ST_NOFIT;
			found = 1'b0;
			// Scan upward from the start class for the first non-empty class
			for (int f = fl; f < NUM_LEVELS && f <= 15; f++) begin
				mask = (f == fl) ? (class_bits[f] & (8'hFF << sl)) : class_bits[f];
				if (!found && mask != 8'd0) begin
					found = 1'b1;
					r.status = tfci_pkg::ST_OK;
					r.fl = 4'(f);
					for (int s = 7; s >= 0; s--) begin
						if (mask[s]) begin
							r.sl = 3'(s);
						end
					end
				end
			end
		end
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (idle_mode == 0) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Size spread over every first level, with some tiny and some fully random
	function automatic logic [21:0] pick_size();
		int          r;
		int          p;
		logic [21:0] v;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return 22'($urandom_range(0, 63));
		end else if (r < 15) begin
			return 22'($urandom);
		end
		p = $urandom_range(6, 21);
		v = 22'($urandom);
		return (22'd1 << p) | (v & ((22'd1 << p) - 22'd1));
	endfunction

	// Sample both handshakes, check results, then record accepted words
	always @(posedge clk) begin
		class_report_t exp_r;
		in_acc <= in_valid && in_ready;
		out_acc <= out_valid && out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_reports.size() == 0) begin
					$display("%0t: unexpected word status %0d fl %0d sl %0d", $time,
						status, first_level, second_level);
					errors++;
				end else begin
					exp_r = due_reports.pop_front();
					status_seen[status]++;
					if ({status, first_level, second_level} !== exp_r) begin
						$display("%0t: mismatch expected st %0d fl %0d sl %0d, actual st %0d fl %0d sl %0d",
							$time, exp_r.status, exp_r.fl, exp_r.sl,
							status, first_level, second_level);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				cmd_seen[command]++;
				due_reports.push_back(index_step(command, size));
			end
		end
	end

	// Driver: hold the word until taken, then idle or present the next one
	always @(negedge clk) begin
		request_t w;
		if (arst_n && (!in_valid || in_acc)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (request_words.size() > 0) begin
				w = request_words.pop_front();
				command <= w.cmd;
				size <= w.sz;
				in_valid <= 1'b1;
				gap_left = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls after each word, plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (want_hold && !hold_taken) begin
				hold_taken = 1'b1;
				ready_wait = HOLD_CYCLES;
			end else if (out_acc && ready_wait == 0) begin
				ready_wait = pick_gap();
			end
			if (ready_wait > 0) begin
				ready_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic offer(input logic [1:0] c, input logic [21:0] s);
		request_words.push_back(request_t'{c, s});
	endtask

	// Wait until every queued word is taken and every report has come back
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (request_words.size() != 0 || in_valid || due_reports.size() != 0);
	endtask

	initial begin
		logic [21:0] live [$];
		logic [21:0] sz;
		int          r;
		int          idx;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: size extremes, empty and full lookups, level rollover, unused code
		offer(tfci_pkg::CMD_INSERT, 22'd0);
		offer(tfci_pkg::CMD_INSERT, 22'd63);
		offer(tfci_pkg::CMD_REMOVE, 22'd63);
		offer(tfci_pkg::CMD_LOOKUP, 22'd0);
		offer(tfci_pkg::CMD_INSERT, 22'd64);
		offer(tfci_pkg::CMD_INSERT, 22'd127);
		offer(tfci_pkg::CMD_INSERT, 22'h3FFFFF);
		offer(tfci_pkg::CMD_REMOVE, 22'd100);
		offer(tfci_pkg::CMD_LOOKUP, 22'd0);
		offer(tfci_pkg::CMD_LOOKUP, 22'h3FFFFF);
		offer(tfci_pkg::CMD_LOOKUP, 22'd4194295);
		offer(tfci_pkg::CMD_LOOKUP, 22'd3670008);
		offer(CMD_UNUSED, 22'h3FFFFF);
		offer(CMD_UNUSED, 22'd0);
		offer(tfci_pkg::CMD_INSERT, 22'd1000);
		offer(tfci_pkg::CMD_INSERT, 22'd1000);
		offer(tfci_pkg::CMD_REMOVE, 22'd1000);
		offer(tfci_pkg::CMD_LOOKUP, 22'd500);
		offer(tfci_pkg::CMD_REMOVE, 22'd1000);
		offer(tfci_pkg::CMD_LOOKUP, 22'd500);
		offer(tfci_pkg::CMD_REMOVE, 22'd127);
		offer(tfci_pkg::CMD_REMOVE, 22'd64);
		offer(tfci_pkg::CMD_REMOVE, 22'h3FFFFF);
		offer(tfci_pkg::CMD_LOOKUP, 22'd71);
		offer(tfci_pkg::CMD_LOOKUP, 22'd127);
		drain();

		// Random: mostly inserts, removes of live blocks and lookups, some noise
		for (int chunk = 0; chunk < 5; chunk++) begin
			idle_mode = (chunk == 1) ? 0 : 1;
			if (chunk == 2) begin
				want_hold = 1'b1;
			end
			for (int n = 0; n < CHUNK_WORDS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					sz = pick_size();
					if (sz >= tfci_pkg::MIN_BLOCK) begin
						live.push_back(sz);
					end
					offer(tfci_pkg::CMD_INSERT, sz);
				end else if (r < 65) begin
					if (live.size() > 0 && $urandom_range(0, 3) != 0) begin
						idx = $urandom_range(0, live.size() - 1);
						sz = live[idx];
						live.delete(idx);
					end else begin
						sz = pick_size();
					end
					offer(tfci_pkg::CMD_REMOVE, sz);
				end else if (r < 90) begin
					offer(tfci_pkg::CMD_LOOKUP, pick_size());
				end else if (r < 95) begin
					offer(CMD_UNUSED, 22'($urandom));
				end else begin
					offer(2'($urandom), 22'($urandom));
				end
			end
			drain();
		end

		repeat (10) @(posedge clk);
		#1;
		if (due_reports.size() != 0) begin
			$display("%0t: %0d reports never arrived", $time, due_reports.size());
			errors++;
		end
		$display("Covered %0d inserts, %0d removes, %0d lookups, %0d unused-code words.",
			cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
		$display("Reports: ok %0d, no fit %0d, small %0d, range %0d, empty %0d, full %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4], status_seen[5]);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#5000000;
		$display("%0t: timeout", $time);
		$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/tfci_pkg.sv
rtl/tfci_ram.sv
rtl/tfci_class.sv
rtl/tfci_find.sv
rtl/tlsf_free_class_index.sv
sim/testbench.sv
